// ===== rtl/scaled_playback_clock_assert.svh =====
`ifndef SCALED_PLAYBACK_CLOCK_ASSERT_SVH
`define SCALED_PLAYBACK_CLOCK_ASSERT_SVH

// condition implies consequence in the same cycle
`define SPC_ASSERT_NOW(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (cons)) \
		else $error("spc check failed");

// condition implies consequence in the next cycle
`define SPC_ASSERT_NEXT(label, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (cons)) \
		else $error("spc check failed");

`endif

// ===== rtl/spc_pkg.sv =====
package spc_pkg;

	localparam int TIME_W     = 48;
	localparam int SPEED_FRAC = 8;
	localparam int POS_FRAC   = 16;
	localparam int GRAN_W     = 32;
	localparam int SPEED_W    = 16;
	localparam int DELTA_W    = 32;
	localparam int KIND_W     = 3;
	localparam int CFG_IDX_W  = 3;

	localparam int POS_W      = POS_FRAC + 1;
	localparam int DVD_W      = TIME_W + POS_FRAC;
	localparam int MUL_W      = GRAN_W + SPEED_W;
	localparam int CNT_W      = $clog2(DVD_W + 1);

	localparam int OUT_USED_W = POS_W + TIME_W + 2;
	localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
	localparam int OUT_USER_W = 2;

	localparam logic [GRAN_W-1:0]  GRANULE_RST = GRAN_W'(1000);
	localparam logic [SPEED_W-1:0] SPEED_RST   = SPEED_W'(256);

	typedef enum logic [KIND_W-1:0] {
		KIND_START  = 3'd0,
		KIND_STOP   = 3'd1,
		KIND_PAUSE  = 3'd2,
		KIND_RESUME = 3'd3,
		KIND_TICK   = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DURATION = 3'd0,
		CFG_INFINITE = 3'd1,
		CFG_OFFSET   = 3'd2,
		CFG_GRANULE  = 3'd3,
		CFG_SPEED    = 3'd4
	} cfg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ELMOD,
		ST_TMUL,
		ST_OFFMOD,
		ST_SMUL,
		ST_DATEMOD,
		ST_POSCHK,
		ST_POSDIV,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/scaled_playback_clock.sv =====
// start: offset modulo, speed multiply, date modulo (skipped at zero speed); running tick:
// elapsed modulo, then delta multiply if accepted; then a position divide when needed
// throughput: one event at a time, the next beat is taken the cycle after the result is
// registered, and a stalled result holds the input side off
// bit-serial restoring dividers (one quotient bit per cycle) and a shift-add multiplier
// arst_n low clears flags, date, elapsed time, output valid; granule 1000, speed 256, others 0
module scaled_playback_clock (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [spc_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [spc_pkg::TIME_W-1:0]             cfg_data,
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  logic [spc_pkg::DELTA_W-1:0]            s_axis_tdata,  // delta_us
	input  logic [spc_pkg::KIND_W-1:0]             s_axis_tuser,  // kind
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// position_q16, date_now_us, is_running, is_paused, zero pad
	output logic [spc_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
	output logic [spc_pkg::OUT_USER_W-1:0]         m_axis_tuser   // notify, accepted
);

	localparam int TW = spc_pkg::TIME_W;

	spc_pkg::state_t state_q, state_d;

	logic [TW-1:0]                  dur_q, dur_d;
	logic                           inf_q, inf_d;
	logic [TW-1:0]                  off_q, off_d;
	logic [spc_pkg::GRAN_W-1:0]     gran_q, gran_d;
	logic [spc_pkg::SPEED_W-1:0]    spd_q, spd_d;

	logic                           running_q, running_d;
	logic                           paused_q, paused_d;
	logic [TW-1:0]                  date_q, date_d;
	logic [TW-1:0]                  el_q, el_d;
	logic                           m_valid_q, m_valid_d;

	logic                           notify_q, notify_d;
	logic                           accepted_q, accepted_d;
	logic [spc_pkg::DELTA_W-1:0]    delta_q, delta_d;
	logic [spc_pkg::POS_W-1:0]      pos_q, pos_d;

	logic [spc_pkg::DVD_W-1:0]      dvd_q, dvd_d;
	logic [TW-1:0]                  rem_q, rem_d;
	logic [TW-1:0]                  dsr_q, dsr_d;
	logic [spc_pkg::CNT_W-1:0]      cnt_q, cnt_d;
	logic [spc_pkg::MUL_W-1:0]      mpa_q, mpa_d;
	logic [spc_pkg::SPEED_W-1:0]    mpb_q, mpb_d;
	logic [spc_pkg::MUL_W-1:0]      prod_q, prod_d;

	logic                           o_notify_q, o_notify_d;
	logic                           o_accepted_q, o_accepted_d;
	logic [spc_pkg::POS_W-1:0]      o_pos_q, o_pos_d;
	logic [TW-1:0]                  o_date_q, o_date_d;
	logic                           o_running_q, o_running_d;
	logic                           o_paused_q, o_paused_d;

	logic [TW:0]                    div_sh;
	logic                           div_ge;
	logic [TW-1:0]                  div_rem;
	logic [spc_pkg::DVD_W-1:0]      div_dvd;
	logic [spc_pkg::MUL_W-1:0]      mul_sum;
	logic [spc_pkg::GRAN_W-1:0]     gran_eff;
	logic [spc_pkg::MUL_W-1:0]      inc;
	logic [TW:0]                    date_sum;
	logic [TW:0]                    el_sum;

	// one restoring divide step and one shift-add multiply step
	assign div_sh  = {rem_q, dvd_q[spc_pkg::DVD_W-1]};
	assign div_ge  = div_sh >= {1'b0, dsr_q};
	assign div_rem = div_ge ? TW'(div_sh - {1'b0, dsr_q}) : div_sh[TW-1:0];
	assign div_dvd = {dvd_q[spc_pkg::DVD_W-2:0], div_ge};
	assign mul_sum = prod_q + (mpb_q[0] ? mpa_q : '0);

	assign gran_eff = (gran_q == '0) ? spc_pkg::GRAN_W'(1) : gran_q;
	assign inc      = prod_q >> spc_pkg::SPEED_FRAC;
	assign date_sum = {1'b0, date_q} + (TW + 1)'(inc);
	assign el_sum   = {1'b0, el_q} + (TW + 1)'(delta_q);

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = (state_q == spc_pkg::ST_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = {o_accepted_q, o_notify_q};
	assign m_axis_tdata  = {(spc_pkg::OUT_DATA_W - spc_pkg::OUT_USED_W)'(0),
		o_paused_q, o_running_q, o_date_q, o_pos_q};

	always_comb begin
		state_d      = state_q;
		dur_d        = dur_q;
		inf_d        = inf_q;
		off_d        = off_q;
		gran_d       = gran_q;
		spd_d        = spd_q;
		running_d    = running_q;
		paused_d     = paused_q;
		date_d       = date_q;
		el_d         = el_q;
		m_valid_d    = m_valid_q && !m_axis_tready;
		notify_d     = notify_q;
		accepted_d   = accepted_q;
		delta_d      = delta_q;
		pos_d        = pos_q;
		dvd_d        = dvd_q;
		rem_d        = rem_q;
		dsr_d        = dsr_q;
		cnt_d        = cnt_q;
		mpa_d        = mpa_q;
		mpb_d        = mpb_q;
		prod_d       = prod_q;
		o_notify_d   = o_notify_q;
		o_accepted_d = o_accepted_q;
		o_pos_d      = o_pos_q;
		o_date_d     = o_date_q;
		o_running_d  = o_running_q;
		o_paused_d   = o_paused_q;

		if (cfg_valid) begin
			case (spc_pkg::cfg_idx_t'(cfg_index))
				spc_pkg::CFG_DURATION: dur_d  = cfg_data;
				spc_pkg::CFG_INFINITE: inf_d  = cfg_data[0];
				spc_pkg::CFG_OFFSET:   off_d  = cfg_data;
				spc_pkg::CFG_GRANULE:  gran_d = cfg_data[spc_pkg::GRAN_W-1:0];
				spc_pkg::CFG_SPEED:    spd_d  = cfg_data[spc_pkg::SPEED_W-1:0];
				default: ;
			endcase
		end

		case (state_q)
			spc_pkg::ST_IDLE: begin
				if (s_axis_tvalid) begin
					delta_d    = s_axis_tdata;
					notify_d   = 1'b0;
					accepted_d = 1'b0;
					state_d    = spc_pkg::ST_POSCHK;
					case (spc_pkg::kind_t'(s_axis_tuser))
						spc_pkg::KIND_START: begin
							if (!inf_q && dur_q <= off_q) begin
								running_d = 1'b0;
								paused_d  = 1'b0;
							end else if (!running_q) begin
								running_d = 1'b1;
								paused_d  = 1'b0;
								notify_d  = 1'b1;
								rem_d     = '0;
								dvd_d     = {off_q, spc_pkg::POS_FRAC'(0)};
								dsr_d     = TW'(gran_eff);
								cnt_d     = spc_pkg::CNT_W'(TW);
								state_d   = spc_pkg::ST_OFFMOD;
							end
						end
						spc_pkg::KIND_STOP: begin
							running_d = 1'b0;
							paused_d  = 1'b0;
						end
						spc_pkg::KIND_PAUSE:  paused_d = 1'b1;
						spc_pkg::KIND_RESUME: paused_d = 1'b0;
						spc_pkg::KIND_TICK: begin
							if (running_q && !paused_q) begin
								rem_d   = '0;
								dvd_d   = {el_q, spc_pkg::POS_FRAC'(0)};
								dsr_d   = TW'(gran_eff);
								cnt_d   = spc_pkg::CNT_W'(TW);
								state_d = spc_pkg::ST_ELMOD;
							end
						end
						default: ;
					endcase
				end
			end
			spc_pkg::ST_OFFMOD: begin
				if (cnt_q != '0) begin
					rem_d = div_rem;
					dvd_d = div_dvd;
					cnt_d = cnt_q - spc_pkg::CNT_W'(1);
				end else begin
					el_d    = off_q - rem_q;
					mpa_d   = spc_pkg::MUL_W'(gran_eff);
					mpb_d   = spd_q;
					prod_d  = '0;
					cnt_d   = spc_pkg::CNT_W'(spc_pkg::SPEED_W);
					state_d = spc_pkg::ST_SMUL;
				end
			end
			spc_pkg::ST_SMUL: begin
				if (cnt_q != '0) begin
					prod_d = mul_sum;
					mpa_d  = mpa_q << 1;
					mpb_d  = mpb_q >> 1;
					cnt_d  = cnt_q - spc_pkg::CNT_W'(1);
				end else if (prod_q == '0) begin
					date_d  = '0;
					state_d = spc_pkg::ST_POSCHK;
				end else begin
					rem_d   = '0;
					dvd_d   = {off_q, spc_pkg::POS_FRAC'(0)};
					dsr_d   = TW'(prod_q);
					cnt_d   = spc_pkg::CNT_W'(TW + spc_pkg::SPEED_FRAC);
					state_d = spc_pkg::ST_DATEMOD;
				end
			end
			spc_pkg::ST_DATEMOD: begin
				if (cnt_q != '0) begin
					rem_d = div_rem;
					dvd_d = div_dvd;
					cnt_d = cnt_q - spc_pkg::CNT_W'(1);
				end else begin
					date_d  = off_q - (rem_q >> spc_pkg::SPEED_FRAC)
						- TW'(rem_q[spc_pkg::SPEED_FRAC-1:0] != '0);
					state_d = spc_pkg::ST_POSCHK;
				end
			end
			spc_pkg::ST_ELMOD: begin
				if (cnt_q != '0) begin
					rem_d = div_rem;
					dvd_d = div_dvd;
					cnt_d = cnt_q - spc_pkg::CNT_W'(1);
				end else if (({1'b0, rem_q[spc_pkg::GRAN_W-1:0]} + {1'b0, delta_q})
						>= {1'b0, gran_eff}) begin
					mpa_d   = spc_pkg::MUL_W'(delta_q);
					mpb_d   = spd_q;
					prod_d  = '0;
					cnt_d   = spc_pkg::CNT_W'(spc_pkg::SPEED_W);
					state_d = spc_pkg::ST_TMUL;
				end else begin
					state_d = spc_pkg::ST_POSCHK;
				end
			end
			spc_pkg::ST_TMUL: begin
				if (cnt_q != '0) begin
					prod_d = mul_sum;
					mpa_d  = mpa_q << 1;
					mpb_d  = mpb_q >> 1;
					cnt_d  = cnt_q - spc_pkg::CNT_W'(1);
				end else begin
					date_d     = date_sum[TW] ? '1 : date_sum[TW-1:0];
					el_d       = el_sum[TW] ? '1 : el_sum[TW-1:0];
					accepted_d = 1'b1;
					notify_d   = 1'b1;
					state_d    = spc_pkg::ST_POSCHK;
				end
			end
			spc_pkg::ST_POSCHK: begin
				// end of playback after an advancing tick
				if (accepted_q && !inf_q && date_q > dur_q) begin
					running_d = 1'b0;
					paused_d  = 1'b0;
				end
				if (inf_q) begin
					pos_d   = '0;
					state_d = spc_pkg::ST_DONE;
				end else if (dur_q == '0 || {1'b0, date_q} >= {dur_q, 1'b0}) begin
					pos_d   = '1;
					state_d = spc_pkg::ST_DONE;
				end else begin
					rem_d   = {1'b0, date_q[TW-1:1]};
					dvd_d   = {date_q[0], (spc_pkg::DVD_W - 1)'(0)};
					dsr_d   = dur_q;
					cnt_d   = spc_pkg::CNT_W'(spc_pkg::POS_W);
					state_d = spc_pkg::ST_POSDIV;
				end
			end
			spc_pkg::ST_POSDIV: begin
				if (cnt_q != '0) begin
					rem_d = div_rem;
					dvd_d = div_dvd;
					cnt_d = cnt_q - spc_pkg::CNT_W'(1);
				end else begin
					pos_d   = dvd_q[spc_pkg::POS_W-1:0];
					state_d = spc_pkg::ST_DONE;
				end
			end
			spc_pkg::ST_DONE: begin
				if (!m_valid_q || m_axis_tready) begin
					m_valid_d    = 1'b1;
					o_notify_d   = notify_q;
					o_accepted_d = accepted_q;
					o_pos_d      = pos_q;
					o_date_d     = date_q;
					o_running_d  = running_q;
					o_paused_d   = paused_q;
					state_d      = spc_pkg::ST_IDLE;
				end
			end
			default: state_d = spc_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= spc_pkg::ST_IDLE;
			dur_q     <= '0;
			inf_q     <= 1'b0;
			off_q     <= '0;
			gran_q    <= spc_pkg::GRANULE_RST;
			spd_q     <= spc_pkg::SPEED_RST;
			running_q <= 1'b0;
			paused_q  <= 1'b0;
			date_q    <= '0;
			el_q      <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			dur_q     <= dur_d;
			inf_q     <= inf_d;
			off_q     <= off_d;
			gran_q    <= gran_d;
			spd_q     <= spd_d;
			running_q <= running_d;
			paused_q  <= paused_d;
			date_q    <= date_d;
			el_q      <= el_d;
			m_valid_q <= m_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		notify_q     <= notify_d;
		accepted_q   <= accepted_d;
		delta_q      <= delta_d;
		pos_q        <= pos_d;
		dvd_q        <= dvd_d;
		rem_q        <= rem_d;
		dsr_q        <= dsr_d;
		cnt_q        <= cnt_d;
		mpa_q        <= mpa_d;
		mpb_q        <= mpb_d;
		prod_q       <= prod_d;
		o_notify_q   <= o_notify_d;
		o_accepted_q <= o_accepted_d;
		o_pos_q      <= o_pos_d;
		o_date_q     <= o_date_d;
		o_running_q  <= o_running_d;
		o_paused_q   <= o_paused_d;
	end

endmodule

// ===== rtl/spc_checker.sv =====
`include "scaled_playback_clock_assert.svh"

module spc_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [spc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	input logic [spc_pkg::OUT_USER_W-1:0] m_axis_tuser
);

	localparam int PAD_LO = spc_pkg::OUT_USED_W;
	localparam int PAD_HI = spc_pkg::OUT_DATA_W - 1;

	logic [spc_pkg::OUT_USER_W+spc_pkg::OUT_DATA_W-1:0] m_beat;

	assign m_beat = {m_axis_tuser, m_axis_tdata};

	// accepted tick always notifies
	`SPC_ASSERT_NOW(a_accept_notifies, m_axis_tvalid && m_axis_tuser[1], m_axis_tuser[0])

	// pad bits above the packed fields stay zero
	`SPC_ASSERT_NOW(a_pad_zero, m_axis_tvalid, m_axis_tdata[PAD_HI:PAD_LO] == '0)

	// one event in flight: the input side closes after a beat
	`SPC_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)

	// a stalled output beat holds
	`SPC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_beat))

endmodule

bind scaled_playback_clock spc_checker u_spc_checker (.*);
